// File: rtl/core/s2cd_pkg.sv
// ----------------------------------------------------------------------------
// Seconds to calendar date package
// Shared constants, types and calendar functions for the converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

	localparam int YEAR_SPAN = 100;
	localparam int YEAR_W    = 7;
	localparam int REM_W     = 32;
	localparam int DIV_W     = 25;
	localparam int STEP_W    = 1;
	localparam int DOY_W     = 9;

	localparam logic [DIV_W-1:0] SECS_PER_YEAR = 25'd31536000;
	localparam logic [DIV_W-1:0] SECS_PER_LEAP = 25'd31622400;
	localparam logic [16:0]      SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0]      SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0]      SECS_PER_MIN  = 17'd60;

	localparam logic [18:0]      DAY_RECIP  = 19'd397683;
	localparam logic [17:0]      HOUR_RECIP = 18'd149131;
	localparam logic [12:0]      MIN_RECIP  = 13'd4370;

	localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(1);

	localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(YEAR_SPAN - 1);

	typedef enum logic [1:0] {
		DIV_DAY  = 2'd0,
		DIV_HOUR = 2'd1,
		DIV_MIN  = 2'd2
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_YEAR = 3'd1,
		ST_DAY  = 3'd2,
		ST_HOUR = 3'd3,
		ST_MIN  = 3'd4,
		ST_DONE = 3'd5
	} state_t;

	typedef struct packed {
		logic     load;
		logic     year_step;
		logic     div_load;
		logic     div_step;
		div_sel_t step_sel;
		logic     result_load;
	} cmd_t;

	typedef struct packed {
		logic year_hit;
		logic year_last;
		logic div_last;
	} status_t;

	// Within 2000..2099 the only century year is 2000, which is a leap year.
	function automatic logic year_leap(input logic [YEAR_W-1:0] yoff);
		return (yoff[1:0] == 2'd0);
	endfunction

	// The day divisor is 128 times 675, so the count is shifted first.
	function automatic logic [DOY_W-1:0] div_quotient(input div_sel_t sel,
		input logic [DIV_W-1:0] x);
		logic [39:0]      prod;
		logic [DOY_W-1:0] quo;
		case (sel)
			DIV_DAY: begin
				prod = 40'(x[DIV_W-1:7]) * 40'(DAY_RECIP);
				quo  = prod[36:28];
			end
			DIV_HOUR: begin
				prod = 40'(x[16:0]) * 40'(HOUR_RECIP);
				quo  = prod[37:29];
			end
			DIV_MIN: begin
				prod = 40'(x[11:0]) * 40'(MIN_RECIP);
				quo  = prod[26:18];
			end
			default: begin
				prod = '0;
				quo  = '0;
			end
		endcase
		return quo;
	endfunction

	function automatic logic [REM_W-1:0] div_product(input div_sel_t sel,
		input logic [DOY_W-1:0] q);
		logic [16:0] d;
		case (sel)
			DIV_DAY:  d = SECS_PER_DAY;
			DIV_HOUR: d = SECS_PER_HOUR;
			DIV_MIN:  d = SECS_PER_MIN;
			default:  d = '0;
		endcase
		return REM_W'(q) * REM_W'(d);
	endfunction

	function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m);
		case (m)
			4'd1:    return DOY_W'(0);
			4'd2:    return DOY_W'(31);
			4'd3:    return DOY_W'(59);
			4'd4:    return DOY_W'(90);
			4'd5:    return DOY_W'(120);
			4'd6:    return DOY_W'(151);
			4'd7:    return DOY_W'(181);
			4'd8:    return DOY_W'(212);
			4'd9:    return DOY_W'(243);
			4'd10:   return DOY_W'(273);
			4'd11:   return DOY_W'(304);
			4'd12:   return DOY_W'(334);
			default: return DOY_W'(0);
		endcase
	endfunction

endpackage

// File: rtl/core/s2cd_datapath.sv
// ----------------------------------------------------------------------------
// Seconds to calendar date datapath
// Year walk by subtraction, shared reciprocal dividers and the result register.
// ----------------------------------------------------------------------------
module s2cd_datapath import s2cd_pkg::*; (
	input  logic                clk,
	input  cmd_t                cmd,
	input  logic [REM_W-1:0]    seconds_count,
	output status_t             status,
	output logic [YEAR_W-1:0]   year_offset,
	output logic [3:0]          month_number,
	output logic [4:0]          day_of_month,
	output logic [4:0]          hour_of_day,
	output logic [5:0]          minute_of_hour,
	output logic [5:0]          second_of_minute,
	output logic                out_of_range
);

	logic [REM_W-1:0]  rem_q;
	logic [YEAR_W-1:0] year_q;
	logic              oor_q;
	logic [STEP_W-1:0] k_q;
	logic [DOY_W-1:0]  quo_q;
	logic [DOY_W-1:0]  day_q;
	logic [4:0]        hour_q;
	logic [5:0]        min_q;

	logic [DIV_W-1:0]  year_len;
	logic [DOY_W-1:0]  quo_c;
	logic              leap;
	logic [DOY_W-1:0]  doy;
	logic [3:0]        month_c;
	logic [DOY_W-1:0]  day_c;

	assign year_len = year_leap(year_q) ? SECS_PER_LEAP : SECS_PER_YEAR;

	assign status.year_hit  = (rem_q < REM_W'(year_len));
	assign status.year_last = (year_q == YEAR_LAST);
	assign status.div_last  = (k_q == '0);

	assign quo_c = div_quotient(cmd.step_sel, rem_q[DIV_W-1:0]);

	always_comb begin
		leap    = year_leap(year_q);
		doy     = day_q + DOY_W'(1);
		month_c = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (doy > month_start(4'(i)) + DOY_W'((i > 2) && leap)) begin
				month_c = 4'(i);
			end
		end
		day_c = doy - month_start(month_c) - DOY_W'((month_c > 4'd2) && leap);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= seconds_count;
			year_q <= '0;
			oor_q  <= 1'b0;
		end
		if (cmd.year_step && !status.year_hit) begin
			if (status.year_last) begin
				oor_q <= 1'b1;
			end else begin
				rem_q  <= rem_q - REM_W'(year_len);
				year_q <= year_q + YEAR_W'(1);
			end
		end
		if (cmd.div_step) begin
			k_q <= k_q - STEP_W'(1);
			if (status.div_last) begin
				rem_q <= rem_q - div_product(cmd.step_sel, quo_q);
				case (cmd.step_sel)
					DIV_DAY:  day_q  <= quo_q;
					DIV_HOUR: hour_q <= quo_q[4:0];
					DIV_MIN:  min_q  <= quo_q[5:0];
					default:  day_q  <= quo_q;
				endcase
			end else begin
				quo_q <= quo_c;
			end
		end
		if (cmd.div_load) begin
			k_q <= DIV_FIRST;
		end
		if (cmd.result_load) begin
			if (oor_q) begin
				year_offset      <= '0;
				month_number     <= 4'd1;
				day_of_month     <= 5'd1;
				hour_of_day      <= '0;
				minute_of_hour   <= '0;
				second_of_minute <= '0;
				out_of_range     <= 1'b1;
			end else begin
				year_offset      <= year_q;
				month_number     <= month_c;
				day_of_month     <= day_c[4:0];
				hour_of_day      <= hour_q;
				minute_of_hour   <= min_q;
				second_of_minute <= rem_q[5:0];
				out_of_range     <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/s2cd_ctrl.sv
// ----------------------------------------------------------------------------
// Seconds to calendar date controller
// Sequences the year walk and the three divisions and owns the output beat.
// ----------------------------------------------------------------------------
module s2cd_ctrl import s2cd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_YEAR;
			end
			ST_YEAR: begin
				if (status.year_hit) state_d = ST_DAY;
				else if (status.year_last) state_d = ST_DONE;
			end
			ST_DAY: begin
				if (status.div_last) state_d = ST_HOUR;
			end
			ST_HOUR: begin
				if (status.div_last) state_d = ST_MIN;
			end
			ST_MIN: begin
				if (status.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{load: 1'b0, year_step: 1'b0, div_load: 1'b0,
			div_step: 1'b0, step_sel: DIV_DAY, result_load: 1'b0};
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_YEAR: begin
				cmd.year_step = 1'b1;
				cmd.div_load  = status.year_hit;
			end
			ST_DAY: begin
				cmd.div_step = 1'b1;
				cmd.step_sel = DIV_DAY;
				cmd.div_load = status.div_last;
			end
			ST_HOUR: begin
				cmd.div_step = 1'b1;
				cmd.step_sel = DIV_HOUR;
				cmd.div_load = status.div_last;
			end
			ST_MIN: begin
				cmd.div_step = 1'b1;
				cmd.step_sel = DIV_MIN;
			end
			ST_DONE: begin
				cmd.result_load = out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_YEAR))
		else $error("accepted beat did not start the year walk");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("result overwrote a stalled output beat");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.year_step, cmd.div_step, cmd.result_load}))
		else $error("conflicting datapath commands");

endmodule

// File: rtl/core/seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// Seconds to calendar date converter
// Turns seconds since 2000-01-01 00:00:00 into year offset, date and time.
// ----------------------------------------------------------------------------
//  beat    | handshake          | payload
//  input   | in_valid, in_stall | seconds_count
//  output  | out_valid,out_stall| year_offset .. second_of_minute, out_of_range
//
// A conversion walks over the years from the accepting edge, one subtraction per
// cycle, and goes straight to the result beat for a count beyond the span.
// Otherwise each of the three divisions then takes a quotient step and a
// remainder step, and the result is registered last.
// A new beat is taken as soon as the previous result is registered, even
// while it is still stalled at the output. Reset clears the controller only.
module seconds_to_calendar_date import s2cd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [REM_W-1:0]  seconds_count,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [YEAR_W-1:0] year_offset,
	output logic [3:0]        month_number,
	output logic [4:0]        day_of_month,
	output logic [4:0]        hour_of_day,
	output logic [5:0]        minute_of_hour,
	output logic [5:0]        second_of_minute,
	output logic              out_of_range
);

	cmd_t    cmd;
	status_t status;

	s2cd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	s2cd_datapath u_datapath (
		.clk              (clk),
		.cmd              (cmd),
		.seconds_count    (seconds_count),
		.status           (status),
		.year_offset      (year_offset),
		.month_number     (month_number),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.out_of_range     (out_of_range)
	);

	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (year_offset <= YEAR_LAST))
		else $error("year offset beyond covered span");

	a_oor_default: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (year_offset == '0 && month_number == 4'd1 &&
		day_of_month == 5'd1 && hour_of_day == '0))
		else $error("out of range beat without default date");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_of_range) |-> (month_number >= 4'd1 && month_number <= 4'd12
		&& day_of_month >= 5'd1 && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59))
		else $error("calendar fields out of range");

endmodule

// File: tb/sv/tb_seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// Seconds to calendar date converter testbench
// Sends second counts through the input channel and checks every result beat
// against a calendar predictor that walks the years and months on its own.
// Directed counts hit the field limits, the leap days and the edge of the
// covered span. Random counts follow in three phases of input and output
// idling.
// ----------------------------------------------------------------------------
module tb_seconds_to_calendar_date;
	import s2cd_pkg::*;

	localparam int unsigned SECS_IN_DAY = 86400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 130;

	typedef struct packed {
		logic [YEAR_W-1:0] year_offset;
		logic [3:0]        month_number;
		logic [4:0]        day_of_month;
		logic [4:0]        hour_of_day;
		logic [5:0]        minute_of_hour;
		logic [5:0]        second_of_minute;
		logic              out_of_range;
	} calendar_date_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [REM_W-1:0]  seconds_count = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [YEAR_W-1:0] year_offset;
	logic [3:0]        month_number;
	logic [4:0]        day_of_month;
	logic [4:0]        hour_of_day;
	logic [5:0]        minute_of_hour;
	logic [5:0]        second_of_minute;
	logic              out_of_range;

	logic [31:0]    pending_seconds[$];
	calendar_date_t expected_dates[$];
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             fail_count = 0;
	int             quiet_cycles = 0;

	seconds_to_calendar_date uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.seconds_count    (seconds_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.year_offset      (year_offset),
		.month_number     (month_number),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.out_of_range     (out_of_range)
	);

	function automatic bit is_leap_year(input int unsigned yoff);
		int unsigned year;
		year = yoff + 2000;
		return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
	endfunction

	function automatic longint unsigned year_length(input int unsigned yoff);
		return longint'(is_leap_year(yoff) ? 366 : 365) * SECS_IN_DAY;
	endfunction

	function automatic longint unsigned year_start(input int unsigned yoff);
		longint unsigned total;
		total = 0;
		for (int unsigned y = 0; y < yoff; y++)
			total += year_length(y);
		return total;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
		case (month)
			2:       return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic calendar_date_t predict_calendar_date(input logic [31:0] secs);
		calendar_date_t date;
		longint unsigned left;
		int unsigned yoff, day_idx, secday, month;
		bit leap;
		date = '0;
		left = secs;
		yoff = 0;
		while (yoff < YEAR_SPAN && left >= year_length(yoff)) begin
			left -= year_length(yoff);
			yoff++;
		end
		if (yoff >= YEAR_SPAN) begin
			date.month_number = 4'd1;
			date.day_of_month = 5'd1;
			date.out_of_range = 1'b1;
			return date;
		end
		leap = is_leap_year(yoff);
		day_idx = int'(left / SECS_IN_DAY);
		secday = int'(left % SECS_IN_DAY);
		month = 1;
		while (day_idx >= days_in_month(month, leap)) begin
			day_idx -= days_in_month(month, leap);
			month++;
		end
		date.year_offset = YEAR_W'(yoff);
		date.month_number = 4'(month);
		date.day_of_month = 5'(day_idx + 1);
		date.hour_of_day = 5'(secday / 3600);
		date.minute_of_hour = 6'((secday % 3600) / 60);
		date.second_of_minute = 6'(secday % 60);
		return date;
	endfunction

	// Mostly counts inside the span, with day and span edges favored.
	function automatic logic [31:0] random_seconds();
		int unsigned pick, yoff;
		longint unsigned base, span;
		pick = $urandom_range(99);
		yoff = $urandom_range(YEAR_SPAN - 1);
		base = year_start(yoff);
		span = year_length(yoff);
		if (pick < 15)
			return $urandom;
		else if (pick < 25)
			return 32'(year_start(YEAR_SPAN) + $urandom_range(200) - 100);
		else if (pick < 50)
			return 32'(base + longint'(SECS_IN_DAY) * $urandom_range(32'(span / SECS_IN_DAY - 1))
				+ ($urandom_range(1) ? SECS_IN_DAY - 1 : 0));
		else
			return 32'(base + $urandom_range(32'(span - 1)));
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++)
			pending_seconds.push_back(random_seconds());
		while (pending_seconds.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned expected,
		input int unsigned actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			fail_count++;
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			seconds_count <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				expected_dates.push_back(predict_calendar_date(seconds_count));
			if (pending_seconds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				seconds_count <= pending_seconds.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		calendar_date_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					$error("result beat with no input waiting for it");
					fail_count++;
				end else begin
					want = expected_dates.pop_front();
					check_field("year_offset", want.year_offset, year_offset);
					check_field("month_number", want.month_number, month_number);
					check_field("day_of_month", want.day_of_month, day_of_month);
					check_field("hour_of_day", want.hour_of_day, hour_of_day);
					check_field("minute_of_hour", want.minute_of_hour, minute_of_hour);
					check_field("second_of_minute", want.second_of_minute, second_of_minute);
					check_field("out_of_range", want.out_of_range, out_of_range);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		pending_seconds.push_back(32'd0);
		pending_seconds.push_back(32'd1);
		pending_seconds.push_back(32'd59);
		pending_seconds.push_back(32'd60);
		pending_seconds.push_back(32'd3599);
		pending_seconds.push_back(32'd3600);
		pending_seconds.push_back(SECS_IN_DAY - 1);
		pending_seconds.push_back(SECS_IN_DAY);
		pending_seconds.push_back(31 * SECS_IN_DAY - 1);
		pending_seconds.push_back(31 * SECS_IN_DAY);
		pending_seconds.push_back(59 * SECS_IN_DAY);
		pending_seconds.push_back(60 * SECS_IN_DAY);
		pending_seconds.push_back(32'(year_start(1) - 1));
		pending_seconds.push_back(32'(year_start(1)));
		pending_seconds.push_back(32'(year_start(1) + 59 * SECS_IN_DAY - 1));
		pending_seconds.push_back(32'(year_start(1) + 59 * SECS_IN_DAY));
		pending_seconds.push_back(32'(year_start(4) + 59 * SECS_IN_DAY));
		pending_seconds.push_back(32'(year_start(YEAR_SPAN - 1)));
		pending_seconds.push_back(32'(year_start(YEAR_SPAN) - 1));
		pending_seconds.push_back(32'(year_start(YEAR_SPAN)));
		pending_seconds.push_back(32'(year_start(YEAR_SPAN) + 1));
		pending_seconds.push_back(32'h7FFF_FFFF);
		pending_seconds.push_back(32'h8000_0000);
		pending_seconds.push_back(32'hFFFF_FFFF);
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		run_phase(26, 66, 200);
		run_phase(66, 26, 200);
		run_phase(0, 0, 200);
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
